// File: src/ptc_pkg.sv
// Shared types, constants and helpers for the pressure/temperature compensation block.
// Has no dependencies; ptc_div_cell, ptc_div and the top module import it.
package ptc_pkg;

	localparam int unsigned DIV_W = 32;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AC1_AC2 = 3'd0,
		CFG_AC3_AC4 = 3'd1,
		CFG_AC5_AC6 = 3'd2,
		CFG_B1_B2 = 3'd3,
		CFG_MC_MD = 3'd4,
		CFG_OSS = 3'd5
	} cfg_idx_t;

	localparam logic [31:0] RST_AC1_AC2 = 32'd26804152;
	localparam logic [31:0] RST_AC3_AC4 = 32'd3352395749;
	localparam logic [31:0] RST_AC5_AC6 = 32'd2146785905;
	localparam logic [31:0] RST_B1_B2 = 32'd405667844;
	localparam logic [31:0] RST_MC_MD = 32'd3724086068;
	localparam logic [1:0] RST_OSS = 2'd0;

	localparam logic [31:0] K_TEMP_OFS = 32'd4000;
	localparam logic [31:0] K_HALF = 32'd32768;
	localparam logic [15:0] K_B7_SCALE = 16'd50000;
	localparam logic [31:0] K_C1 = 32'd3038;
	localparam logic [31:0] K_C2 = 32'hFFFF_E343;
	localparam logic [31:0] K_C3 = 32'd3791;

	function automatic logic [31:0] asr32(logic [31:0] v, int unsigned n);
		asr32 = 32'($signed(v) >>> n);
	endfunction

	function automatic logic [31:0] sext16(logic [15:0] v);
		sext16 = {{16{v[15]}}, v};
	endfunction

endpackage

// File: src/ptc_if.sv
// Valid/ready channels for the raw input word and the compensated result word.
// Depends on nothing but the payload widths of the block.
interface ptc_in_if;
	logic valid;
	logic ready;
	logic [15:0] raw_temp;
	logic [18:0] raw_pressure;
	modport source (output valid, raw_temp, raw_pressure, input ready);
	modport sink (input valid, raw_temp, raw_pressure, output ready);
endinterface

interface ptc_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] temperature;
	logic signed [31:0] pressure;
	logic div_error;
	modport source (output valid, temperature, pressure, div_error, input ready);
	modport sink (input valid, temperature, pressure, div_error, output ready);
endinterface

// File: src/ptc_div_cell.sv
// One restoring-division step: shifts one dividend bit into the remainder and
// emits one quotient bit. Uses ptc_pkg for the data width.
module ptc_div_cell
	import ptc_pkg::*;
#(
	parameter int unsigned SW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_i,
	input  logic [DIV_W-1:0] rem_i,
	input  logic [DIV_W-1:0] a_i,
	input  logic [DIV_W-1:0] b_i,
	input  logic [SW-1:0] side_i,
	output logic valid_o,
	output logic [DIV_W-1:0] rem_o,
	output logic [DIV_W-1:0] a_o,
	output logic [DIV_W-1:0] b_o,
	output logic [SW-1:0] side_o
);
	logic [DIV_W:0] trial;
	logic ge;
	logic [DIV_W:0] diff;

	always_comb begin
		trial = {rem_i, a_i[DIV_W-1]};
		ge = trial >= {1'b0, b_i};
		diff = trial - {1'b0, b_i};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else if (en) begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			a_o <= {a_i[DIV_W-2:0], ge};
			b_o <= b_i;
			side_o <= side_i;
		end
	end
endmodule

// File: src/ptc_div.sv
// Unsigned divider built as a row of ptc_div_cell stages, one quotient bit per
// cell, with a side word carried alongside. Uses ptc_pkg and ptc_div_cell.
module ptc_div
	import ptc_pkg::*;
#(
	parameter int unsigned SW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_i,
	input  logic [DIV_W-1:0] a_i,
	input  logic [DIV_W-1:0] b_i,
	input  logic [SW-1:0] side_i,
	output logic valid_o,
	output logic [DIV_W-1:0] q_o,
	output logic [SW-1:0] side_o
);
	logic v_w [0:DIV_W];
	logic [DIV_W-1:0] rem_w [0:DIV_W];
	logic [DIV_W-1:0] a_w [0:DIV_W];
	logic [DIV_W-1:0] b_w [0:DIV_W];
	logic [SW-1:0] side_w [0:DIV_W];

	assign v_w[0] = valid_i;
	assign rem_w[0] = '0;
	assign a_w[0] = a_i;
	assign b_w[0] = b_i;
	assign side_w[0] = side_i;

	for (genvar i = 0; i < DIV_W; i++) begin : g_cell
		ptc_div_cell #(.SW(SW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_i(v_w[i]), .rem_i(rem_w[i]), .a_i(a_w[i]), .b_i(b_w[i]),
			.side_i(side_w[i]),
			.valid_o(v_w[i+1]), .rem_o(rem_w[i+1]), .a_o(a_w[i+1]),
			.b_o(b_w[i+1]), .side_o(side_w[i+1])
		);
	end

	assign valid_o = v_w[DIV_W];
	assign q_o = a_w[DIV_W];
	assign side_o = side_w[DIV_W];
endmodule

// File: src/pressure_temp_compensation_top.sv
// Pressure/temperature compensation: a fixed pipeline of 83 register stages, 64 of
// which form two 32-cell division rows. One word is taken every cycle, and the whole
// pipeline holds while the output register is full and not taken. arst_n clears all
// valid bits and loads the calibration registers with their defaults. Uses ptc_pkg,
// ptc_if and ptc_div.
module pressure_temp_compensation_top
	import ptc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	ptc_in_if.sink in_ch,
	ptc_out_if.source out_ch,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int unsigned SW1 = 32 + 19 + 2;
	localparam int unsigned SW2 = 32 + 3;

	logic [31:0] cal_ac1_ac2_q, cal_ac3_ac4_q, cal_ac5_ac6_q, cal_b1_b2_q, cal_mc_md_q;
	logic [1:0] oss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_ac1_ac2_q <= RST_AC1_AC2;
			cal_ac3_ac4_q <= RST_AC3_AC4;
			cal_ac5_ac6_q <= RST_AC5_AC6;
			cal_b1_b2_q <= RST_B1_B2;
			cal_mc_md_q <= RST_MC_MD;
			oss_q <= RST_OSS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_AC1_AC2: cal_ac1_ac2_q <= cfg_data;
				CFG_AC3_AC4: cal_ac3_ac4_q <= cfg_data;
				CFG_AC5_AC6: cal_ac5_ac6_q <= cfg_data;
				CFG_B1_B2: cal_b1_b2_q <= cfg_data;
				CFG_MC_MD: cal_mc_md_q <= cfg_data;
				CFG_OSS: oss_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = sext16(cal_ac1_ac2_q[31:16]);
	assign ac2 = sext16(cal_ac1_ac2_q[15:0]);
	assign ac3 = sext16(cal_ac3_ac4_q[31:16]);
	assign ac4 = {16'd0, cal_ac3_ac4_q[15:0]};
	assign ac5 = {16'd0, cal_ac5_ac6_q[31:16]};
	assign ac6 = {16'd0, cal_ac5_ac6_q[15:0]};
	assign b1 = sext16(cal_b1_b2_q[31:16]);
	assign b2 = sext16(cal_b1_b2_q[15:0]);
	assign mc = sext16(cal_mc_md_q[31:16]);
	assign md = sext16(cal_mc_md_q[15:0]);

	logic en;
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	// Valid bits of the plain stages; the division rows carry their own.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17, v_s18, v_s19;
	logic d1_valid, d2_valid;
	logic [31:0] q1, q2;
	logic [SW1-1:0] side1;
	logic [SW2-1:0] side2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10} <= '0;
			{v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17, v_s18, v_s19} <= '0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= d1_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= d2_valid;
			v_s16 <= v_s15;
			v_s17 <= v_s16;
			v_s18 <= v_s17;
			v_s19 <= v_s18;
		end
	end

	// Temperature front end and division operands.
	logic [31:0] m1_s1, x1_s2, den_s2, num_s3, den_s3;
	logic [18:0] up_s1, up_s2, up_s3;
	logic [31:0] x1_s3;
	logic negq_s3, zero_s3;
	logic [31:0] num_full;
	assign num_full = mc << 11;

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s1 <= (32'(in_ch.raw_temp) - ac6) * ac5;
			up_s1 <= in_ch.raw_pressure;
			x1_s2 <= asr32(m1_s1, 15);
			den_s2 <= asr32(m1_s1, 15) + md;
			up_s2 <= up_s1;
			num_s3 <= num_full[31] ? 32'(0) - num_full : num_full;
			den_s3 <= den_s2[31] ? 32'(0) - den_s2 : den_s2;
			negq_s3 <= num_full[31] ^ den_s2[31];
			zero_s3 <= den_s2 == '0;
			x1_s3 <= x1_s2;
			up_s3 <= up_s2;
		end
	end

	ptc_div #(.SW(SW1)) u_div_temp (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid_i(v_s3), .a_i(num_s3), .b_i(den_s3),
		.side_i({x1_s3, up_s3, negq_s3, zero_s3}),
		.valid_o(d1_valid), .q_o(q1), .side_o(side1)
	);

	logic [31:0] d1_x1;
	logic [18:0] d1_up;
	logic d1_negq, d1_zero;
	assign {d1_x1, d1_up, d1_negq, d1_zero} = side1;

	logic [31:0] x2_s4, x1_s4, b5_s5, t_s6, b6_s6;
	logic [18:0] up_s4, up_s5, up_s6, up_s7, up_s8, up_s9, up_s10, up_s11;
	logic [31:0] t_s7, t_s8, t_s9, t_s10, t_s11, t_s12, t_s13, t_s14;
	logic err_s4, err_s5, err_s6, err_s7, err_s8, err_s9, err_s10, err_s11;
	logic err_s12, err_s13, err_s14;
	logic [31:0] sqm_s7, a2m_s7, a3m_s7, sq_s8, x1a_s8, x1c_s8;
	logic [31:0] mb2_s9, mb1_s9, x1a_s9, x1c_s9, x3_s10, x4_s10;
	logic [31:0] b3_s11, xx_s11, b4_s12, d_s12, b4_s13, b7_s13;
	logic [15:0] scale_s12;
	logic [31:0] a_s14, b4_s14;
	logic big_s14;

	always_ff @(posedge clk) begin
		if (en) begin
			// A zero divisor forces the quotient to all ones.
			x2_s4 <= d1_zero ? '1 : (d1_negq ? 32'(0) - q1 : q1);
			x1_s4 <= d1_x1;
			up_s4 <= d1_up;
			err_s4 <= d1_zero;

			b5_s5 <= x1_s4 + x2_s4;
			up_s5 <= up_s4;
			err_s5 <= err_s4;

			t_s6 <= asr32(b5_s5 + 32'd8, 4);
			b6_s6 <= b5_s5 - K_TEMP_OFS;
			up_s6 <= up_s5;
			err_s6 <= err_s5;

			sqm_s7 <= b6_s6 * b6_s6;
			a2m_s7 <= ac2 * b6_s6;
			a3m_s7 <= ac3 * b6_s6;
			t_s7 <= t_s6;
			up_s7 <= up_s6;
			err_s7 <= err_s6;

			sq_s8 <= asr32(sqm_s7, 12);
			x1a_s8 <= asr32(a2m_s7, 11);
			x1c_s8 <= asr32(a3m_s7, 13);
			t_s8 <= t_s7;
			up_s8 <= up_s7;
			err_s8 <= err_s7;

			mb2_s9 <= b2 * sq_s8;
			mb1_s9 <= b1 * sq_s8;
			x1a_s9 <= x1a_s8;
			x1c_s9 <= x1c_s8;
			t_s9 <= t_s8;
			up_s9 <= up_s8;
			err_s9 <= err_s8;

			x3_s10 <= asr32(mb2_s9, 11) + x1a_s9;
			x4_s10 <= asr32(x1c_s9 + asr32(mb1_s9, 16) + 32'd2, 2);
			t_s10 <= t_s9;
			up_s10 <= up_s9;
			err_s10 <= err_s9;

			b3_s11 <= asr32(((ac1 * 32'd4 + x3_s10) << oss_q) + 32'd2, 2);
			xx_s11 <= x4_s10 + K_HALF;
			t_s11 <= t_s10;
			up_s11 <= up_s10;
			err_s11 <= err_s10;

			b4_s12 <= (ac4 * xx_s11) >> 15;
			d_s12 <= 32'(up_s11) - b3_s11;
			scale_s12 <= K_B7_SCALE >> oss_q;
			t_s12 <= t_s11;
			err_s12 <= err_s11;

			b7_s13 <= d_s12 * 32'(scale_s12);
			b4_s13 <= b4_s12;
			t_s13 <= t_s12;
			err_s13 <= err_s12;

			// Large b7 is divided first and doubled afterwards, as the formula does.
			big_s14 <= b7_s13[31];
			a_s14 <= b7_s13[31] ? b7_s13 : b7_s13 << 1;
			b4_s14 <= b4_s13;
			t_s14 <= t_s13;
			err_s14 <= err_s13;
		end
	end

	ptc_div #(.SW(SW2)) u_div_pres (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid_i(v_s14), .a_i(a_s14), .b_i(b4_s14),
		.side_i({t_s14, err_s14, big_s14, b4_s14 == '0}),
		.valid_o(d2_valid), .q_o(q2), .side_o(side2)
	);

	logic [31:0] d2_t;
	logic d2_err, d2_big, d2_zero;
	assign {d2_t, d2_err, d2_big, d2_zero} = side2;

	logic [31:0] p_s15, p_s16, p_s17, p_s18, x1_s16, m_s16, x1sq_s17, x2_s17;
	logic [31:0] x2_s18, x1m_s18, p_s19;
	logic [31:0] t_s15, t_s16, t_s17, t_s18, t_s19;
	logic err_s15, err_s16, err_s17, err_s18, err_s19;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s15 <= d2_big ? q2 << 1 : q2;
			t_s15 <= d2_t;
			err_s15 <= d2_err | d2_zero;

			x1_s16 <= asr32(p_s15, 8);
			m_s16 <= K_C2 * p_s15;
			p_s16 <= p_s15;
			t_s16 <= t_s15;
			err_s16 <= err_s15;

			x1sq_s17 <= x1_s16 * x1_s16;
			x2_s17 <= asr32(m_s16, 16);
			p_s17 <= p_s16;
			t_s17 <= t_s16;
			err_s17 <= err_s16;

			x1m_s18 <= x1sq_s17 * K_C1;
			x2_s18 <= x2_s17;
			p_s18 <= p_s17;
			t_s18 <= t_s17;
			err_s18 <= err_s17;

			p_s19 <= p_s18 + asr32(asr32(x1m_s18, 16) + x2_s18 + K_C3, 4);
			t_s19 <= t_s18;
			err_s19 <= err_s18;
		end
	end

	assign out_ch.valid = v_s19;
	assign out_ch.temperature = $signed(t_s19);
	assign out_ch.pressure = $signed(p_s19);
	assign out_ch.div_error = err_s19;

	a_div_temp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(d1_valid && d1_zero) |-> (q1 == '1))
		else $error("temperature division by zero did not give all ones");

	a_div_pres_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(d2_valid && d2_zero) |-> (q2 == '1))
		else $error("pressure division by zero did not give all ones");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && v_s18) |=> (v_s18 && $stable(p_s18)))
		else $error("pipeline moved while the output was stalled");
endmodule
